// ===== rtl/core/ordered_index_key_encoder_unit_assert.svh =====
// assertion macros for the key encoder unit
// no dependencies; included by the modules that carry checks
`ifndef ORDERED_INDEX_KEY_ENCODER_UNIT_ASSERT_SVH
`define ORDERED_INDEX_KEY_ENCODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define OKIEK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
`define OKIEK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OKIEK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define OKIEK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/okiek_pkg.sv =====
// shared types, codes and constants for the key encoder unit
// no dependencies
package okiek_pkg;

	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned FRAME_BYTES     = 8;
	localparam int unsigned CNT_W           = $clog2(FRAME_BYTES + 1);
	localparam int unsigned IDX_W           = $clog2(FRAME_BYTES);
	localparam int unsigned MAX_COLUMNS_DEF = 64;
	localparam int unsigned MASK_W          = 64;
	localparam int unsigned COUNT_W         = 7;

	localparam logic [3:0] FUNC_NULL    = 4'd0;
	localparam logic [3:0] FUNC_BOOL    = 4'd1;
	localparam logic [3:0] FUNC_INT32   = 4'd2;
	localparam logic [3:0] FUNC_INT64   = 4'd3;
	localparam logic [3:0] FUNC_FLOAT   = 4'd4;
	localparam logic [3:0] FUNC_DOUBLE  = 4'd5;
	localparam logic [3:0] FUNC_STR     = 4'd6;
	localparam logic [3:0] FUNC_STR_END = 4'd7;
	localparam logic [3:0] FUNC_ROWLOC  = 4'd8;
	localparam logic [3:0] FUNC_BITMAP  = 4'd9;

	localparam logic [31:0] SIGN32 = 32'h8000_0000;
	localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

	localparam logic [BYTE_W-1:0] BYTE_00 = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_01 = 8'h01;
	localparam logic [BYTE_W-1:0] BYTE_02 = 8'h02;
	localparam logic [BYTE_W-1:0] BYTE_FF = 8'hFF;

	typedef struct packed {
		logic [3:0]         func;
		logic [63:0]        value;
		logic [7:0]         str_byte;
		logic [31:0]        page_id;
		logic [7:0]         slot;
		logic [COUNT_W-1:0] key_cols;
		logic [MASK_W-1:0]  null_mask;
	} item_t;

	// bytes in emission order, data[0] first
	typedef struct packed {
		logic [FRAME_BYTES-1:0][BYTE_W-1:0] data;
		logic [CNT_W-1:0]                   count;
	} frame_t;

endpackage

// ===== rtl/core/ordered_index_key_encoder_unit.sv =====
// top level of the order-preserving key encoder
// depends on okiek_pkg, okiek_encode, okiek_serialiser and the assertion macro header
`include "ordered_index_key_encoder_unit_assert.svh"

// Turns one key part per input transaction into its memcmp-ordered byte encoding and
// delivers it one byte per output transaction, with last on the final byte of the part.
// An accepted part is held in an input register, encoded combinationally and loaded into
// the result frame register, from which its first byte is offered; a busy frame register
// holds the part in the input register. The result channel moves one byte per cycle while
// out_ready is high; a part holds the frame register until its last byte (of 1 to 8) is taken.
// The next part is taken while the current frame still drains; parts that give no
// bytes (unused kinds, bitmaps of fewer than two columns) produce no output.
module ordered_index_key_encoder_unit
	import okiek_pkg::*;
#(
	parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         func,
	input  logic [63:0]        value,
	input  logic [7:0]         str_byte,
	input  logic [31:0]        page_id,
	input  logic [7:0]         slot,
	input  logic [COUNT_W-1:0] key_cols,
	input  logic [MASK_W-1:0]  null_mask,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               last
);

	item_t  item_s1;
	logic   valid_s1;
	frame_t enc_frame;
	logic   load_ready;
	logic   accept;

	assign in_ready = !valid_s1 || load_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{func: func, value: value, str_byte: str_byte, page_id: page_id,
				slot: slot, key_cols: key_cols, null_mask: null_mask};
		end
	end

	okiek_encode #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_encode (
		.item (item_s1),
		.frame(enc_frame)
	);

	okiek_serialiser u_serialiser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_valid(valid_s1),
		.load_frame(enc_frame),
		.load_ready(load_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	`OKIEK_ASSERT_IMPL(a_stall_only_when_full, clk, arst_n, !in_ready, valid_s1,
		"input stalled with empty input register")
	`OKIEK_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !load_ready,
		valid_s1 && $stable(item_s1), "input register changed while stalled")

endmodule

// ===== rtl/core/okiek_encode.sv =====
// combinational encoder: one key part to up to eight ordered bytes
// depends on okiek_pkg
module okiek_encode
	import okiek_pkg::*;
#(
	parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
	input  item_t  item,
	output frame_t frame
);

	localparam logic [COUNT_W-1:0] MaxCols = COUNT_W'(MAX_COLUMNS);

	logic [31:0]        f32;
	logic [63:0]        f64;
	logic [31:0]        i32;
	logic [63:0]        i64;
	logic [COUNT_W-1:0] cols;
	logic [MASK_W-1:0]  mask;
	logic [COUNT_W-1:0] nbytes;

	always_comb begin
		i32 = item.value[31:0] ^ SIGN32;
		i64 = item.value ^ SIGN64;
		f32 = item.value[31] ? ~item.value[31:0] : (item.value[31:0] | SIGN32);
		f64 = item.value[63] ? ~item.value : (item.value | SIGN64);
		cols = (item.key_cols > MaxCols) ? MaxCols : item.key_cols;
		for (int i = 0; i < MASK_W; i++) begin
			mask[i] = item.null_mask[i] & (COUNT_W'(i) < cols);
		end
		nbytes = (cols + COUNT_W'(7)) >> 3;
	end

	always_comb begin
		frame.data  = '0;
		frame.count = '0;
		unique case (item.func)
			FUNC_NULL: begin
				frame.data[0] = BYTE_00;
				frame.data[1] = BYTE_01;
				frame.count   = CNT_W'(2);
			end
			FUNC_BOOL: begin
				frame.data[0] = item.value[0] ? BYTE_02 : BYTE_01;
				frame.count   = CNT_W'(1);
			end
			FUNC_INT32: begin
				for (int i = 0; i < 4; i++) frame.data[i] = i32[31-8*i -: 8];
				frame.count = CNT_W'(4);
			end
			FUNC_INT64: begin
				for (int i = 0; i < 8; i++) frame.data[i] = i64[63-8*i -: 8];
				frame.count = CNT_W'(8);
			end
			FUNC_FLOAT: begin
				for (int i = 0; i < 4; i++) frame.data[i] = f32[31-8*i -: 8];
				frame.count = CNT_W'(4);
			end
			FUNC_DOUBLE: begin
				for (int i = 0; i < 8; i++) frame.data[i] = f64[63-8*i -: 8];
				frame.count = CNT_W'(8);
			end
			FUNC_STR: begin
				if (item.str_byte == BYTE_00) begin
					frame.data[0] = BYTE_00;
					frame.data[1] = BYTE_FF;
					frame.count   = CNT_W'(2);
				end else begin
					frame.data[0] = item.str_byte;
					frame.count   = CNT_W'(1);
				end
			end
			FUNC_STR_END: begin
				frame.data[0] = BYTE_00;
				frame.data[1] = BYTE_00;
				frame.count   = CNT_W'(2);
			end
			FUNC_ROWLOC: begin
				for (int i = 0; i < 4; i++) frame.data[i] = item.page_id[31-8*i -: 8];
				frame.data[4] = item.slot;
				frame.count   = CNT_W'(5);
			end
			FUNC_BITMAP: begin
				// fewer than two columns gives no bitmap
				if (cols >= COUNT_W'(2)) begin
					for (int i = 0; i < 8; i++) frame.data[i] = mask[8*i +: 8];
					frame.count = CNT_W'(nbytes);
				end
			end
			default: begin
				frame.count = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/okiek_serialiser.sv =====
// result register and byte serialiser: holds one encoded frame, hands out a byte per transaction
// depends on okiek_pkg and the assertion macro header
`include "ordered_index_key_encoder_unit_assert.svh"

module okiek_serialiser
	import okiek_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	input  frame_t            load_frame,
	output logic              load_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last
);

	frame_t           frame_s2;
	logic             valid_s2;
	logic [IDX_W-1:0] idx_q;
	logic             take;
	logic             done;
	logic             load;

	assign out_valid  = valid_s2;
	assign out_byte   = frame_s2.data[idx_q];
	assign last       = ({1'b0, idx_q} == (frame_s2.count - CNT_W'(1)));
	assign take       = valid_s2 && out_ready;
	assign done       = take && last;
	assign load_ready = !valid_s2 || done;
	assign load       = load_valid && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (load) begin
				// items with no bytes are dropped here
				valid_s2 <= (load_frame.count != '0);
				idx_q    <= '0;
			end else if (done) begin
				valid_s2 <= 1'b0;
				idx_q    <= '0;
			end else if (take) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_s2 <= load_frame;
		end
	end

	`OKIEK_ASSERT_IMPL(a_count_range, clk, arst_n, valid_s2,
		(frame_s2.count != '0) && (frame_s2.count <= CNT_W'(FRAME_BYTES)),
		"held frame has no bytes or too many")
	`OKIEK_ASSERT_IMPL(a_idx_in_frame, clk, arst_n, valid_s2,
		({1'b0, idx_q} < frame_s2.count), "byte pointer beyond frame")
	`OKIEK_ASSERT_NEXT(a_advance, clk, arst_n, take && !last,
		valid_s2 && (idx_q == $past(idx_q) + IDX_W'(1)) && $stable(frame_s2),
		"frame lost or pointer skipped mid item")

endmodule
